### rtl/box_filter_and_overlap_suppression_top_assert.svh
// Assertion macros for the box filter and overlap suppression block.
`ifndef BOX_FILTER_AND_OVERLAP_SUPPRESSION_TOP_ASSERT_SVH
`define BOX_FILTER_AND_OVERLAP_SUPPRESSION_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define BFOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfos assertion failed");

// Next-cycle implication
`define BFOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfos assertion failed");

`else

`define BFOS_ASSERT_IMP(lbl, ante, cons)
`define BFOS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/bfos_pkg.sv
// Shared types and constants of the box filter and overlap suppression block.
package bfos_pkg;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned CONF_W  = 10;
  localparam int unsigned IOU_W   = 9;
  localparam int unsigned AREA_W  = 2 * SIZE_W;
  localparam int unsigned UNION_W = AREA_W + 1;
  localparam int unsigned PROD_W  = IOU_W + UNION_W;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONF_THR = 2'd0;
  localparam logic [1:0] CFG_IOU_THR  = 2'd1;

  // Stored box: position, size and confidence
  typedef struct packed {
    logic [CONF_W-1:0]        conf;
    logic [SIZE_W-1:0]        h;
    logic [SIZE_W-1:0]        w;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  x;
  } box_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic upd;    // kept candidate is offered to the store this cycle
    logic shift;  // store moves one place toward the head
  } bfos_ctrl_t;

endpackage

### rtl/box_filter_and_overlap_suppression_top.sv
// Top level of the box filter and overlap suppression block.
// Candidate boxes arrive one per transaction on the in_ channel; boxes that
// fail the confidence, size or aspect test are discarded, the rest are
// compared against a row of MAX_BOXES store cells, each of which runs its own
// four-stage overlap pipeline against the broadcast candidate. A candidate
// therefore occupies the block through the accept, the four pipeline stages
// and the store update, and no new candidate is taken during that time. On a
// transaction with tlast set, the store then drains toward the head cell, one
// result per cycle while the out_ side is ready (one empty result if nothing
// was stored), after which the store is empty and the next candidate is
// accepted. An output register separates the two sides, so the first
// candidate of the next frame can be taken while the last result still waits.
// Configuration: index 0 is the confidence threshold, index 1 the IoU
// threshold scaled by 256; write them only while the block is idle.
`include "box_filter_and_overlap_suppression_top_assert.svh"

module box_filter_and_overlap_suppression_top #(
  parameter int unsigned MAX_BOXES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // Candidate input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // box_x, box_y, box_w, box_h, box_conf, zero pad
  input  logic        in_tlast,   // frame_end
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_x, out_y, out_w, out_h, out_conf, zero pad
  output logic [1:0]  out_tuser,  // face_valid, dropped_any
  output logic        out_tlast   // run_last
);
  import bfos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OVL, S_MUL, S_UNI, S_CMP, S_UPD, S_EMIT
  } state_t;

  state_t              state_r;
  logic [CONF_W-1:0]   conf_thr_r;
  logic [IOU_W-1:0]    iou_thr_r;
  box_t                cand_r;
  logic [AREA_W-1:0]   cand_area_r;
  logic                keep_r, last_r, overflow_r;
  logic                out_valid_r, out_face_r, out_last_r, out_drop_r;
  box_t                out_box_r;

  box_t                in_box;
  logic                in_fire, keep_in;
  logic [SIZE_W-1:0]   in_w12, in_h12;
  logic [SIZE_W+1:0]   w3;
  logic [SIZE_W+3:0]   h10;
  logic                out_free, emit_load, emit_last, head_valid;
  logic                any_hit, full;
  bfos_ctrl_t          ctrl;

  box_t                box_chain  [MAX_BOXES+1];
  logic [AREA_W-1:0]   area_chain [MAX_BOXES+1];
  logic [MAX_BOXES:0]  vld_ext;
  logic [MAX_BOXES:0]  hit_chain;
  logic [MAX_BOXES:0]  prev_vld;
  logic [MAX_BOXES-1:0] valid_vec, wr_vec;
  logic [MAX_BOXES:0]  vld_plus1;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_thr_r <= 10'd512;
      iou_thr_r  <= 9'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CONF_THR: conf_thr_r <= cfg_data;
        CFG_IOU_THR:  iou_thr_r  <= cfg_data[IOU_W-1:0];
        default: ;
      endcase
    end
  end

  // Candidate unpack and keep test
  assign in_box.x    = in_tdata[12:0];
  assign in_box.y    = in_tdata[25:13];
  assign in_box.w    = in_tdata[37:26];
  assign in_box.h    = in_tdata[50:39];
  assign in_box.conf = in_tdata[61:52];
  assign in_w12      = in_tdata[37:26];
  assign in_h12      = in_tdata[50:39];
  assign w3  = {2'b00, in_w12} + {1'b0, in_w12, 1'b0};
  assign h10 = {1'b0, in_h12, 3'b000} + {3'b000, in_h12, 1'b0};
  assign keep_in = (in_tdata[61:52] >= conf_thr_r)
                 && !in_tdata[38] && (in_w12 != '0)
                 && !in_tdata[51] && (in_h12 != '0)
                 && (h10 >= {2'b00, w3}) && ({2'b00, in_h12} <= w3);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  // Store cell row
  assign box_chain[MAX_BOXES]  = '0;
  assign area_chain[MAX_BOXES] = '0;
  assign vld_ext[MAX_BOXES]    = 1'b0;
  assign hit_chain[0]          = 1'b0;
  assign prev_vld              = {valid_vec, 1'b1};
  assign vld_ext[MAX_BOXES-1:0] = valid_vec;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    bfos_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cand       (cand_r),
      .cand_area  (cand_area_r),
      .iou_thr    (iou_thr_r),
      .hit_in     (hit_chain[i]),
      .prev_valid (prev_vld[i]),
      .any_hit    (any_hit),
      .nbr_box    (box_chain[i+1]),
      .nbr_area   (area_chain[i+1]),
      .nbr_valid  (vld_ext[i+1]),
      .box        (box_chain[i]),
      .area       (area_chain[i]),
      .valid      (valid_vec[i]),
      .hit_out    (hit_chain[i+1]),
      .wr         (wr_vec[i])
    );
  end

  assign any_hit    = hit_chain[MAX_BOXES];
  assign full       = valid_vec[MAX_BOXES-1];
  assign head_valid = valid_vec[0];

  // Emission: load the output register from the head cell
  assign out_free   = ~out_valid_r | out_tready;
  assign emit_load  = (state_r == S_EMIT) & out_free;
  assign emit_last  = head_valid ? ~vld_ext[1] : 1'b1;
  assign ctrl.upd   = (state_r == S_UPD) & keep_r;
  assign ctrl.shift = emit_load & head_valid;

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_r <= 1'b1;
        out_box_r   <= head_valid ? box_chain[0] : '0;
        out_face_r  <= head_valid;
        out_last_r  <= emit_last;
        out_drop_r  <= overflow_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= S_OVL;
        S_OVL:  state_r <= S_MUL;
        S_MUL:  state_r <= S_UNI;
        S_UNI:  state_r <= S_CMP;
        S_CMP:  state_r <= S_UPD;
        S_UPD: begin
          if (keep_r && !any_hit && full) overflow_r <= 1'b1;
          state_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_load && emit_last) begin
            overflow_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Candidate payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand_r <= in_box;
      keep_r <= keep_in;
      last_r <= in_tlast;
    end
    if (state_r == S_OVL) begin
      cand_area_r <= {{SIZE_W{1'b0}}, cand_r.w} * {{SIZE_W{1'b0}}, cand_r.h};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_box_r};
  assign out_tuser  = {out_drop_r, out_face_r};
  assign out_tlast  = out_last_r;

  // Checks
  assign vld_plus1 = {1'b0, valid_vec} + {{MAX_BOXES{1'b0}}, 1'b1};

  `BFOS_ASSERT_IMP(a_single_writer, 1'b1, $onehot0(wr_vec))
  `BFOS_ASSERT_IMP(a_store_packed, 1'b1, (valid_vec & vld_plus1[MAX_BOXES-1:0]) == '0)
  `BFOS_ASSERT_NXT(a_store_drained, emit_load && emit_last, valid_vec == '0)

endmodule

### rtl/bfos_cell.sv
// One store cell: a box slot with its overlap pipeline against the candidate.
module bfos_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfos_pkg::bfos_ctrl_t          ctrl,
  input  bfos_pkg::box_t                cand,
  input  logic [bfos_pkg::AREA_W-1:0]   cand_area,
  input  logic [bfos_pkg::IOU_W-1:0]    iou_thr,
  input  logic                          hit_in,
  input  logic                          prev_valid,
  input  logic                          any_hit,
  input  bfos_pkg::box_t                nbr_box,
  input  logic [bfos_pkg::AREA_W-1:0]   nbr_area,
  input  logic                          nbr_valid,
  output bfos_pkg::box_t                box,
  output logic [bfos_pkg::AREA_W-1:0]   area,
  output logic                          valid,
  output logic                          hit_out,
  output logic                          wr
);
  import bfos_pkg::*;

  box_t                box_r;
  logic [AREA_W-1:0]   area_r;
  logic                valid_r;
  logic [SIZE_W-1:0]   iw_r, ih_r;
  logic [AREA_W-1:0]   inter_r, inter_d_r;
  logic [PROD_W-1:0]   prod_r;
  logic                match_r;
  logic [SIZE_W-1:0]   iw_nxt, ih_nxt;
  logic [AREA_W-1:0]   inter_nxt;
  logic [UNION_W-1:0]  uni;
  logic [PROD_W-1:0]   prod_nxt;
  logic                hit_here, repl, app;

  // Overlap length of two intervals, clipped at zero
  function automatic logic [SIZE_W-1:0] overlap_1d(
    input logic signed [POS_W-1:0] a, input logic [SIZE_W-1:0] la,
    input logic signed [POS_W-1:0] b, input logic [SIZE_W-1:0] lb);
    logic signed [POS_W:0]   ea, eb, lo, hi;
    logic signed [POS_W+1:0] d;
    ea = $signed({a[POS_W-1], a}) + $signed({2'b00, la});
    eb = $signed({b[POS_W-1], b}) + $signed({2'b00, lb});
    lo = (a > b) ? $signed({a[POS_W-1], a}) : $signed({b[POS_W-1], b});
    hi = (ea < eb) ? ea : eb;
    d  = $signed({hi[POS_W], hi}) - $signed({lo[POS_W], lo});
    return (d > 15'sd0) ? d[SIZE_W-1:0] : '0;
  endfunction

  // Stage 1: overlap widths
  assign iw_nxt = overlap_1d(cand.x, cand.w, box_r.x, box_r.w);
  assign ih_nxt = overlap_1d(cand.y, cand.h, box_r.y, box_r.h);

  // Stage 2: intersection area
  assign inter_nxt = {{SIZE_W{1'b0}}, iw_r} * {{SIZE_W{1'b0}}, ih_r};

  // Stage 3: threshold times union
  assign uni      = {1'b0, cand_area} + {1'b0, area_r} - {1'b0, inter_r};
  assign prod_nxt = {{(PROD_W-IOU_W){1'b0}}, iou_thr} * {{(PROD_W-UNION_W){1'b0}}, uni};

  always_ff @(posedge clk) begin
    iw_r      <= iw_nxt;
    ih_r      <= ih_nxt;
    inter_r   <= inter_nxt;
    inter_d_r <= inter_r;
    prod_r    <= prod_nxt;
    // Stage 4: inter*256 > thr*union
    match_r   <= {{(PROD_W-AREA_W-8){1'b0}}, inter_d_r, 8'h00} > prod_r;
  end

  // First duplicate in store order wins; append goes to the first free slot
  assign hit_here = valid_r & match_r;
  assign hit_out  = hit_in | hit_here;
  assign repl     = ctrl.upd & hit_here & ~hit_in & (cand.conf > box_r.conf);
  assign app      = ctrl.upd & ~valid_r & prev_valid & ~any_hit;
  assign wr       = repl | app;

  // Slot contents
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      box_r  <= nbr_box;
      area_r <= nbr_area;
    end else if (wr) begin
      box_r  <= cand;
      area_r <= cand_area;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= nbr_valid;
    end else if (app) begin
      valid_r <= 1'b1;
    end
  end

  assign box   = box_r;
  assign area  = area_r;
  assign valid = valid_r;

endmodule

### dv/box_filter_and_overlap_suppression_top_tb.sv
// Self-checking testbench for the box filter and overlap suppression block.
module box_filter_and_overlap_suppression_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfos_pkg::*;

  localparam int MAX_BOXES = 32;
  localparam int QUIET_CYCLES = 20;
  localparam int HOLD_CYCLES = 500;
  localparam longint LIMIT_NS = 64'd5_000_000;

  // One emitted result, as seen on out_tdata/out_tuser/out_tlast
  typedef struct packed {
    logic        dropped;
    logic        last;
    logic        valid;
    logic [9:0]  conf;
    logic [11:0] h;
    logic [11:0] w;
    logic [12:0] y;
    logic [12:0] x;
  } face_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // box_x, box_y, box_w, box_h, box_conf, zero pad
  logic        in_tlast = 1'b0; // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // out_x, out_y, out_w, out_h, out_conf, zero pad
  logic [1:0]  out_tuser;       // face_valid, dropped_any
  logic        out_tlast;       // run_last

  box_filter_and_overlap_suppression_top #(.MAX_BOXES(MAX_BOXES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Predictor state: thresholds and the store of unique boxes
  logic [9:0] conf_thr = 10'd512;
  logic [8:0] iou_thr = 9'd128;
  box_t       kept_boxes [MAX_BOXES];
  int         kept_count = 0;
  bit         overflow_flag = 1'b0;
  face_rec_t  pending_faces [$];
  int         mismatch_count = 0;

  // Idle rates in percent, and long hold-off requests for the receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic longint span_overlap(longint a, longint la, longint b, longint lb);
    longint lo;
    longint hi;
    lo = (a > b) ? a : b;
    hi = (a + la < b + lb) ? a + la : b + lb;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Duplicate test without division: inter*256 > thr*union
  function automatic bit boxes_overlap(box_t c, box_t s);
    longint iw;
    longint ih;
    longint inter;
    longint uni;
    iw = span_overlap($signed(c.x), longint'(c.w), $signed(s.x), longint'(s.w));
    ih = span_overlap($signed(c.y), longint'(c.h), $signed(s.y), longint'(s.h));
    inter = iw * ih;
    uni = longint'(c.w) * longint'(c.h) + longint'(s.w) * longint'(s.h) - inter;
    return inter * 256 > longint'(iou_thr) * uni;
  endfunction

  // Filter one accepted candidate into the store; at frame end queue the results
  task automatic apply_candidate(logic [12:0] rx, logic [12:0] ry, logic [12:0] rw,
                                 logic [12:0] rh, logic [9:0] rc, bit frame_end);
    longint    w;
    longint    h;
    bit        keep;
    bit        dup;
    box_t      cand;
    face_rec_t rec;
    w = $signed(rw);
    h = $signed(rh);
    keep = (rc >= conf_thr) && w > 0 && h > 0 && h * 10 >= w * 3 && h <= w * 3;
    cand.x = rx;
    cand.y = ry;
    cand.w = rw[11:0];
    cand.h = rh[11:0];
    cand.conf = rc;
    if (keep) begin
      dup = 1'b0;
      for (int i = 0; i < kept_count; i++) begin
        if (boxes_overlap(cand, kept_boxes[i])) begin
          if (cand.conf > kept_boxes[i].conf) kept_boxes[i] = cand;
          dup = 1'b1;
          break;
        end
      end
      if (!dup) begin
        if (kept_count < MAX_BOXES) begin
          kept_boxes[kept_count] = cand;
          kept_count++;
        end else begin
          overflow_flag = 1'b1;
        end
      end
    end
    if (frame_end) begin
      if (kept_count == 0) begin
        rec = '0;
        rec.last = 1'b1;
        rec.dropped = overflow_flag;
        pending_faces.insert(pending_faces.size(), rec);
      end else begin
        for (int i = 0; i < kept_count; i++) begin
          rec.x = kept_boxes[i].x;
          rec.y = kept_boxes[i].y;
          rec.w = kept_boxes[i].w;
          rec.h = kept_boxes[i].h;
          rec.conf = kept_boxes[i].conf;
          rec.valid = 1'b1;
          rec.last = (i == kept_count - 1);
          rec.dropped = overflow_flag;
          pending_faces.insert(pending_faces.size(), rec);
        end
      end
      kept_count = 0;
      overflow_flag = 1'b0;
    end
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each transaction with the oldest expected result
  always @(posedge clk) begin
    face_rec_t act;
    face_rec_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      act.x = out_tdata[12:0];
      act.y = out_tdata[25:13];
      act.w = out_tdata[37:26];
      act.h = out_tdata[49:38];
      act.conf = out_tdata[59:50];
      act.valid = out_tuser[0];
      act.dropped = out_tuser[1];
      act.last = out_tlast;
      if (pending_faces.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result x=%0d y=%0d w=%0d h=%0d conf=%0d v=%0b l=%0b d=%0b",
                 $time, $signed(act.x), $signed(act.y), act.w, act.h, act.conf,
                 act.valid, act.last, act.dropped);
      end else begin
        exp_rec = pending_faces.pop_front();
        if (act !== exp_rec) begin
          mismatch_count++;
          $display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d conf=%0d v=%0b l=%0b d=%0b",
                   $time, $signed(exp_rec.x), $signed(exp_rec.y), exp_rec.w, exp_rec.h,
                   exp_rec.conf, exp_rec.valid, exp_rec.last, exp_rec.dropped);
          $display("%0t:          actual x=%0d y=%0d w=%0d h=%0d conf=%0d v=%0b l=%0b d=%0b",
                   $time, $signed(act.x), $signed(act.y), act.w, act.h, act.conf,
                   act.valid, act.last, act.dropped);
        end
      end
    end
  end

  // Offer one candidate, with random idle cycles first
  task automatic send_box(int x, int y, int w, int h, int c, bit frame_end);
    logic [12:0] fx;
    logic [12:0] fy;
    logic [12:0] fw;
    logic [12:0] fh;
    logic [9:0]  fc;
    fx = x[12:0];
    fy = y[12:0];
    fw = w[12:0];
    fh = h[12:0];
    fc = c[9:0];
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, fc, fh, fw, fy, fx};
    in_tlast <= frame_end;
    do @(posedge clk); while (!in_tready);
    apply_candidate(fx, fy, fw, fh, fc, frame_end);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[9:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CONF_THR) conf_thr = value[9:0];
    else if (idx == CFG_IOU_THR) iou_thr = value[8:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One frame: clustered candidates with some noise, or sparse mostly unique boxes
  task automatic send_frame(int n_cands, bit sparse);
    int cx [4];
    int cy [4];
    int cw [4];
    int j;
    int bx;
    int by;
    int bw;
    int bh;
    int bc;
    for (int i = 0; i < 4; i++) begin
      cx[i] = int'($urandom_range(8191)) - 4096;
      cy[i] = int'($urandom_range(8191)) - 4096;
      cw[i] = $urandom_range(8, 400);
    end
    for (int k = 0; k < n_cands; k++) begin
      if (!sparse && $urandom_range(99) < 12) begin
        bx = $urandom_range(8191);
        by = $urandom_range(8191);
        bw = $urandom_range(8191);
        bh = $urandom_range(8191);
        bc = $urandom_range(1023);
      end else begin
        j = sparse ? 0 : $urandom_range(3);
        bw = sparse ? $urandom_range(8, 60) : cw[j] + int'($urandom_range(20)) - 10;
        if ($urandom_range(99) < 10) bh = (bw * int'($urandom_range(40))) / 10;
        else bh = (bw * int'($urandom_range(3, 30))) / 10;
        if (sparse) begin
          bx = int'($urandom_range(8191)) - 4096;
          by = int'($urandom_range(8191)) - 4096;
          bc = $urandom_range(512, 1023);
        end else begin
          bx = cx[j] + int'($urandom_range(40)) - 20;
          by = cy[j] + int'($urandom_range(40)) - 20;
          bc = ($urandom_range(9) == 0) ? 1023 : $urandom_range(1023);
        end
      end
      send_box(bx, by, bw, bh, bc, k == n_cands - 1);
    end
  endtask

  // Reject rules and field extremes, then empty frames
  task automatic test_filter_edges();
    send_box(100, 100, 0, 50, 900, 0);
    send_box(100, 100, 50, 0, 900, 0);
    send_box(100, 100, -4096, 50, 900, 0);
    send_box(100, 100, 50, -1, 900, 0);
    send_box(-4096, -4096, 40, 12, 800, 0);    // ratio exactly 0.3
    send_box(-3000, -3000, 40, 11, 800, 0);    // just below 0.3
    send_box(-2000, -2000, 40, 120, 800, 0);   // ratio exactly 3.0
    send_box(-1000, -2000, 40, 121, 800, 0);   // just above 3.0
    send_box(0, 0, 100, 100, 511, 0);
    send_box(0, 0, 100, 100, 512, 0);
    send_box(4095, 4095, 4095, 4095, 1023, 0);
    send_box(-4096, 2000, 4095, 4095, 0, 0);
    send_box(1000, -4096, 4095, 4095, 1023, 0);
    send_box(4095, -4096, 1, 3, 700, 1);
    // empty frames: nothing kept
    send_box(0, 0, -1, -1, 1023, 1);
    send_box(0, 0, 10, 10, 0, 1);
  endtask

  // Replacement on higher confidence, discard on equal or lower, first match wins
  task automatic test_duplicates();
    send_box(0, 0, 100, 100, 600, 0);
    send_box(1000, 0, 100, 100, 600, 0);
    send_box(5, 5, 100, 100, 700, 0);
    send_box(6, 6, 100, 100, 700, 0);
    send_box(1005, 0, 100, 100, 650, 0);
    send_box(50, 0, 100, 100, 1023, 0);
    send_box(30, 3, 100, 100, 690, 1);
  endtask

  // Full store: extra unique boxes are dropped and flagged for that frame only
  task automatic test_store_overflow();
    for (int i = 0; i < 36; i++)
      send_box(-4000 + (i % 6) * 1200, -4000 + (i / 6) * 1200, 100, 100, 800, 0);
    send_box(-4000 + 3 * 1200 + 4, -4000, 100, 100, 1000, 1);
    send_box(0, 0, 0, 0, 0, 1);
  endtask

  // Threshold sweep, extremes included; restores the reset values at the end
  task automatic test_thresholds();
    int conf_set [5] = '{0, 1023, 0, 256, 700};
    int iou_set [5] = '{0, 256, 511, 64, 200};
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_CONF_THR, conf_set[s]);
      write_reg(CFG_IOU_THR, iou_set[s]);
      send_frame(12, 1'b0);
    end
    write_reg(CFG_CONF_THR, 512);
    write_reg(CFG_IOU_THR, 128);
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int n_items, bit hold);
    int sent;
    int n;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (hold) hold_requests++;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(34, 40);
        send_frame(n, 1'b1);
      end else begin
        n = $urandom_range(1, 16);
        send_frame(n, 1'b0);
      end
      sent += n;
    end
    settle();
  endtask

  initial begin
    for (int i = 0; i < MAX_BOXES; i++) kept_boxes[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 84;
    test_filter_edges();
    test_duplicates();
    test_store_overflow();
    test_thresholds();

    test_random_traffic(8, 84, 50, 1'b0);
    test_random_traffic(84, 8, 50, 1'b0);
    test_random_traffic(0, 0, 50, 1'b1);

    settle();
    if (mismatch_count == 0) begin
      $display("box_filter_and_overlap_suppression_top regression: pass");
    end else begin
      $display("box_filter_and_overlap_suppression_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("box_filter_and_overlap_suppression_top regression: fail");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bfos_pkg.sv
rtl/bfos_cell.sv
rtl/box_filter_and_overlap_suppression_top.sv
dv/box_filter_and_overlap_suppression_top_tb.sv
